// File: design/gbnrc_pkg.sv
// Package with the shared constants and types of the go-back-N receiver checksum core.
`timescale 1ns / 1ps

package gbnrc_pkg;

    localparam int MAX_WORDS = 512;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int WORD_W    = 16;
    localparam int SEQ_W     = 8;
    localparam int BYTES_W   = 10;
    localparam int MAX_BYTES = 1020;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef struct packed {
        word_t  word;
        logic   is_last;
        seq_t   seq_num;
        logic   is_fin;
        word_t  rx_checksum;
    } beat_t;

    typedef struct packed {
        seq_t               ack_seq;
        logic               accepted;
        logic [BYTES_W-1:0] payload_bytes;
        logic               fin_seen;
    } result_t;

endpackage

// File: design/gbnrc_checker.sv
// Combinational checksum accumulation and end-of-packet decision for one beat.
`timescale 1ns / 1ps

module gbnrc_checker
    import gbnrc_pkg::*;
(
    input  word_t   sum,
    input  count_t  count,
    input  seq_t    expected,
    input  beat_t   beat,
    output word_t   sum_upd,
    output count_t  count_upd,
    output seq_t    expected_upd,
    output result_t result
);

    localparam int BW = CNT_W + 1;

    logic [WORD_W:0]  raw_sum;
    word_t            folded_sum;
    logic             take;
    logic             good;
    logic [BW-1:0]    bytes_full;
    logic [BYTES_W-1:0] bytes_sat;

    always_comb
    begin
        take       = (count < count_t'(MAX_WORDS));
        raw_sum    = {1'b0, sum} + {1'b0, beat.word};
        folded_sum = raw_sum[WORD_W-1:0] + word_t'(raw_sum[WORD_W]);

        sum_upd   = take ? folded_sum : sum;
        count_upd = take ? count + count_t'(1) : count;

        good = (beat.seq_num == expected) && ((~sum_upd) == beat.rx_checksum);

        if (count_upd >= count_t'(2))
        begin
            bytes_full = {count_upd, 1'b0} - BW'(4);
        end
        else
        begin
            bytes_full = '0;
        end

        if (bytes_full > BW'(MAX_BYTES))
        begin
            bytes_sat = BYTES_W'(MAX_BYTES);
        end
        else
        begin
            bytes_sat = bytes_full[BYTES_W-1:0];
        end

        expected_upd = expected;
        if (good)
        begin
            result.ack_seq       = expected;
            result.accepted      = 1'b1;
            result.payload_bytes = bytes_sat;
            result.fin_seen      = 1'b0;
            expected_upd         = expected + seq_t'(1);
        end
        else
        begin
            result.ack_seq       = expected - seq_t'(1);
            result.accepted      = 1'b0;
            result.payload_bytes = '0;
            result.fin_seen      = beat.is_fin;
        end
    end

endmodule

// File: design/go_back_n_receiver_checksum_core.sv
// Top level of the go-back-N receiver with Internet-checksum check.
//
// Packet words enter on the input channel, one beat per word, with the
// checksum field presented as zero and is_last set on the final word.
// The sequence number, FIN flag and received checksum are taken from the
// last beat. For every last beat one result beat leaves on the output
// channel: the acknowledgement number, the accept flag, the payload byte
// count and the rejected-FIN flag; other beats give no result.
// Each beat is captured in an input register, and the one's-complement add
// with end-around carry and the final compare run from that register into
// the result register once the beat fires. One beat is taken every cycle
// while the output side does not stall a last beat.
// When the output side stalls, a last beat waits in the input register and
// input ready drops only while both registers are full; non-last beats keep
// flowing through since they produce no result.
// Reset clears the running sum, word count, expected sequence number and
// both valid flags; the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module go_back_n_receiver_checksum_core
    import gbnrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        word,
    input  logic               is_last,
    input  logic [7:0]         seq_num,
    input  logic               is_fin,
    input  logic [15:0]        rx_checksum,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         ack_seq,
    output logic               accepted,
    output logic [9:0]         payload_bytes,
    output logic               fin_seen
);

    beat_t   beat_reg;
    logic    beat_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    word_t   sum_reg;
    word_t   sum_next;
    count_t  count_reg;
    count_t  count_next;
    seq_t    expected_reg;
    seq_t    expected_next;

    logic    slot_free;
    logic    fire;
    logic    in_take;

    gbnrc_checker u_checker (
        .sum          (sum_reg),
        .count        (count_reg),
        .expected     (expected_reg),
        .beat         (beat_reg),
        .sum_upd      (sum_next),
        .count_upd    (count_next),
        .expected_upd (expected_next),
        .result       (result_next)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = beat_valid_reg && (!beat_reg.is_last || slot_free);
    assign in_ready  = !beat_valid_reg || fire;
    assign in_take   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            expected_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                beat_valid_reg <= in_valid;
            end

            if (fire)
            begin
                if (beat_reg.is_last)
                begin
                    sum_reg      <= '0;
                    count_reg    <= '0;
                    expected_reg <= expected_next;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                end
            end

            if (fire && beat_reg.is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            beat_reg.word        <= word;
            beat_reg.is_last     <= is_last;
            beat_reg.seq_num     <= seq_num;
            beat_reg.is_fin      <= is_fin;
            beat_reg.rx_checksum <= rx_checksum;
        end
        if (fire && beat_reg.is_last)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ack_seq       = result_reg.ack_seq;
    assign accepted      = result_reg.accepted;
    assign payload_bytes = result_reg.payload_bytes;
    assign fin_seen      = result_reg.fin_seen;

endmodule
